FILE: rtl/b3sic_pkg.sv
// Package for the B3/Sidon incremental checker.
// Shared codes, field widths and the control state type; no dependencies.
`default_nettype none
package b3sic_pkg;

	localparam int VALUE_W  = 8;
	localparam int STATUS_W = 3;
	localparam int DEPTH_W  = 6;
	localparam int OPCODE_W = 2;
	localparam int WORD_W   = 64;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 32;
	localparam logic [VALUE_W-1:0] LIMIT_RESET = 8'd255;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD   = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE   = 3'd0,
		STAT_PAIR   = 3'd1,
		STAT_TRIPLE = 3'd2,
		STAT_RANGE  = 3'd3,
		STAT_FULL   = 3'd4,
		STAT_EMPTY  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ELEM,
		S_PAIR,
		S_TRIP,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/b3sic_if.sv
// Valid/ready channel interfaces for commands and responses.
// Depends on b3sic_pkg for field widths.
`default_nettype none
interface b3sic_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [b3sic_pkg::OPCODE_W-1:0]    opcode;
	logic [b3sic_pkg::VALUE_W-1:0]     value;
	modport source (output valid, opcode, value, input ready);
	modport sink (input valid, opcode, value, output ready);
endinterface

interface b3sic_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [b3sic_pkg::STATUS_W-1:0]    status;
	logic [b3sic_pkg::DEPTH_W-1:0]     depth;
	logic [b3sic_pkg::VALUE_W-1:0]     largest;
	modport source (output valid, status, depth, largest, input ready);
	modport sink (input valid, status, depth, largest, output ready);
endinterface
`default_nettype wire

FILE: rtl/b3sic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module b3sic_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 396
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                   wdata,
	input  wire logic                               re,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic      [WIDTH-1:0]                   rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/b3_set_incremental_checker_unit.sv
// Incremental Sidon/B3 set checker. A try-add walks the elements one per cycle
// to build the new-sum masks, then makes one pass over the pair-sum words and
// one over the triple-sum words, each bound by the single read port of its
// level memory; pop, clear, the unused opcode and refused adds go straight to
// the response state. One command is in flight at a time; the next
// is taken while a response still waits in the output register. Level zero of
// both bitsets reads as zero by masking, so no clearing pass follows reset.
// Depends on b3sic_pkg, b3sic_if and b3sic_ram.
`default_nettype none
module b3_set_incremental_checker_unit #(
	parameter int MAX_VALUE = 255,
	parameter int MAX_DEPTH = 32,
	parameter int WORDS     = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	b3sic_cmd_if.sink                          cmd,
	b3sic_rsp_if.source                        rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [b3sic_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [b3sic_pkg::CFG_DW-1:0]  pwdata,
	output logic      [b3sic_pkg::CFG_DW-1:0]  prdata,
	output logic                               pready
);
	localparam int VW      = b3sic_pkg::VALUE_W;
	localparam int WDW     = b3sic_pkg::WORD_W;
	localparam int BITS    = WORDS * WDW;
	localparam int IDXW    = $clog2(BITS);
	localparam int LVLW    = $clog2(MAX_DEPTH + 1);
	localparam int WW      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int ELW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int RDEPTH  = (MAX_DEPTH + 1) * WORDS;
	localparam int AW      = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
	localparam int SW      = VW + 2;

	b3sic_pkg::state_t  state_q, state_n;
	b3sic_pkg::status_t status_q, acc_status;
	b3sic_pkg::opcode_t op_q;

	logic [LVLW-1:0]  depth_q, depth_n;
	logic [VW-1:0]    largest_q, largest_n;
	logic [VW-1:0]    limit_q;
	logic [VW-1:0]    x_q;
	logic [VW-1:0]    elem_q [MAX_DEPTH];
	logic [ELW-1:0]   idx_q, elem_ra;
	logic [VW-1:0]    elem_rd;
	logic [BITS-1:0]  pmask_q, tmask_q;
	logic [WW-1:0]    w_q, w_s1;
	logic             vld_s1, issue_done_q;
	logic             pcol_q, tcol_q;
	logic             rsp_valid_q;
	logic [b3sic_pkg::STATUS_W-1:0] rsp_status_q;
	logic [b3sic_pkg::DEPTH_W-1:0]  rsp_depth_q;
	logic [VW-1:0]    rsp_largest_q;

	logic             cmd_fire, out_free, resp_load, last_word;
	logic             rd_pair, rd_trip, we_pair, we_trip, add_ok;
	logic [AW-1:0]    raddr, waddr;
	logic [WDW-1:0]   pair_rdata, trip_rdata, pw, tw, pword, tword, lo_w, hi_w;
	logic [SW-1:0]    x2, x3;
	logic [5:0]       bs;
	logic [1:0]       ws;

	// config port
	assign pready = 1'b1;
	assign prdata = b3sic_pkg::CFG_DW'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= b3sic_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			limit_q <= pwdata[VW-1:0];
		end
	end

	assign x2 = {1'b0, cmd.value, 1'b0};
	assign x3 = x2 + SW'(cmd.value);

	// decision for a freshly accepted command
	always_comb begin
		acc_status = b3sic_pkg::STAT_DONE;
		add_ok     = 1'b0;
		case (b3sic_pkg::opcode_t'(cmd.opcode))
			b3sic_pkg::OP_ADD: begin
				if (int'(depth_q) >= MAX_DEPTH) begin
					acc_status = b3sic_pkg::STAT_FULL;
				end else if (cmd.value == '0 || cmd.value > limit_q
						|| int'(cmd.value) > MAX_VALUE || int'(x3) >= BITS
						|| (depth_q != '0 && cmd.value <= largest_q)) begin
					acc_status = b3sic_pkg::STAT_RANGE;
				end else begin
					add_ok = 1'b1;
				end
			end
			b3sic_pkg::OP_POP: begin
				if (depth_q == '0) begin
					acc_status = b3sic_pkg::STAT_EMPTY;
				end
			end
			default: acc_status = b3sic_pkg::STAT_DONE;
		endcase
	end

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign last_word = vld_s1 && (w_s1 == WW'(WORDS - 1));

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			b3sic_pkg::S_IDLE: begin
				if (cmd.valid) begin
					if (add_ok) begin
						state_n = (depth_q != '0) ? b3sic_pkg::S_ELEM : b3sic_pkg::S_PAIR;
					end else begin
						state_n = b3sic_pkg::S_RESP;
					end
				end
			end
			b3sic_pkg::S_ELEM: begin
				if (int'(idx_q) == int'(depth_q) - 1) begin
					state_n = b3sic_pkg::S_PAIR;
				end
			end
			b3sic_pkg::S_PAIR: begin
				if (last_word) begin
					state_n = b3sic_pkg::S_TRIP;
				end
			end
			b3sic_pkg::S_TRIP: begin
				if (last_word) begin
					state_n = b3sic_pkg::S_RESP;
				end
			end
			b3sic_pkg::S_RESP: begin
				if (out_free) begin
					state_n = b3sic_pkg::S_IDLE;
				end
			end
			default: state_n = b3sic_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd.ready = 1'b0;
		rd_pair   = 1'b0;
		rd_trip   = 1'b0;
		we_pair   = 1'b0;
		we_trip   = 1'b0;
		resp_load = 1'b0;
		case (state_q)
			b3sic_pkg::S_IDLE: cmd.ready = 1'b1;
			b3sic_pkg::S_PAIR: begin
				rd_pair = !issue_done_q;
				we_pair = vld_s1;
			end
			b3sic_pkg::S_TRIP: begin
				rd_trip = !issue_done_q;
				we_trip = vld_s1;
			end
			b3sic_pkg::S_RESP: resp_load = out_free;
			default: cmd.ready = 1'b0;
		endcase
	end

	assign cmd_fire = cmd.valid && cmd.ready;

	// level memories: word w of level k lives at k*WORDS + w
	assign raddr = AW'(int'(depth_q) * WORDS + int'(w_q));
	assign waddr = AW'((int'(depth_q) + 1) * WORDS + int'(w_s1));

	// level zero is never written and reads as empty
	assign pw    = (depth_q != '0) ? pair_rdata : '0;
	assign tw    = (depth_q != '0) ? trip_rdata : '0;
	assign pword = pmask_q[int'(w_s1) * WDW +: WDW];
	assign tword = tmask_q[int'(w_s1) * WDW +: WDW];

	b3sic_ram #(.WIDTH(WDW), .DEPTH(RDEPTH)) u_pair_ram (
		.clk   (clk),
		.we    (we_pair),
		.waddr (waddr),
		.wdata (pw | pword),
		.re    (rd_pair),
		.raddr (raddr),
		.rdata (pair_rdata)
	);

	b3sic_ram #(.WIDTH(WDW), .DEPTH(RDEPTH)) u_trip_ram (
		.clk   (clk),
		.we    (we_trip),
		.waddr (waddr),
		.wdata (tw | tword),
		.re    (rd_trip),
		.raddr (raddr),
		.rdata (trip_rdata)
	);

	// pair word shifted up by x lands in words w+ws and w+ws+1
	assign bs   = x_q[5:0];
	assign ws   = x_q[VW-1:6];
	assign lo_w = pw << bs;
	assign hi_w = (bs == '0) ? '0 : (pw >> (7'd64 - {1'b0, bs}));

	// element stack: one read port, counter during the walk, new top on pop
	assign elem_ra = (state_q == b3sic_pkg::S_ELEM) ? idx_q : ELW'(depth_q - LVLW'(2));
	assign elem_rd = elem_q[elem_ra];

	always_comb begin
		depth_n   = depth_q;
		largest_n = largest_q;
		case (op_q)
			b3sic_pkg::OP_ADD: begin
				if (status_q == b3sic_pkg::STAT_DONE) begin
					depth_n   = depth_q + LVLW'(1);
					largest_n = x_q;
				end
			end
			b3sic_pkg::OP_POP: begin
				if (status_q == b3sic_pkg::STAT_DONE) begin
					depth_n   = depth_q - LVLW'(1);
					largest_n = (depth_q == LVLW'(1)) ? '0 : elem_rd;
				end
			end
			b3sic_pkg::OP_CLEAR: begin
				depth_n   = '0;
				largest_n = '0;
			end
			default: depth_n = depth_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= b3sic_pkg::S_IDLE;
			depth_q      <= '0;
			largest_q    <= '0;
			status_q     <= b3sic_pkg::STAT_DONE;
			op_q         <= b3sic_pkg::OP_NONE;
			idx_q        <= '0;
			w_q          <= '0;
			w_s1         <= '0;
			vld_s1       <= 1'b0;
			issue_done_q <= 1'b0;
			pcol_q       <= 1'b0;
			tcol_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			vld_s1  <= rd_pair || rd_trip;
			w_s1    <= w_q;

			if (rd_pair || rd_trip) begin
				w_q <= w_q + WW'(1);
				if (w_q == WW'(WORDS - 1)) begin
					issue_done_q <= 1'b1;
				end
			end else if (state_n != state_q) begin
				w_q          <= '0;
				issue_done_q <= 1'b0;
			end

			if (cmd_fire) begin
				op_q     <= b3sic_pkg::opcode_t'(cmd.opcode);
				status_q <= acc_status;
				idx_q    <= '0;
				pcol_q   <= 1'b0;
				tcol_q   <= 1'b0;
			end

			if (state_q == b3sic_pkg::S_ELEM) begin
				idx_q <= idx_q + ELW'(1);
			end

			if (we_pair) begin
				pcol_q <= pcol_q || ((pw & pword) != '0);
			end
			if (we_trip) begin
				tcol_q <= tcol_q || ((tw & tword) != '0);
				if (last_word) begin
					if (pcol_q) begin
						status_q <= b3sic_pkg::STAT_PAIR;
					end else if (tcol_q || ((tw & tword) != '0)) begin
						status_q <= b3sic_pkg::STAT_TRIPLE;
					end else begin
						status_q <= b3sic_pkg::STAT_DONE;
					end
				end
			end

			if (resp_load) begin
				depth_q     <= depth_n;
				largest_q   <= largest_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			x_q     <= cmd.value;
			pmask_q <= BITS'(1) << x2;
			tmask_q <= BITS'(1) << x3;
		end
		if (state_q == b3sic_pkg::S_ELEM) begin
			pmask_q[IDXW'(SW'(x_q) + SW'(elem_rd))] <= 1'b1;
			tmask_q[IDXW'({1'b0, x_q, 1'b0} + SW'(elem_rd))] <= 1'b1;
		end
		if (we_pair) begin
			for (int k = 0; k < WORDS; k++) begin
				if (k == int'(w_s1) + int'(ws)) begin
					tmask_q[k*WDW +: WDW] <= tmask_q[k*WDW +: WDW] | lo_w;
				end else if (k == int'(w_s1) + int'(ws) + 1) begin
					tmask_q[k*WDW +: WDW] <= tmask_q[k*WDW +: WDW] | hi_w;
				end
			end
		end
		if (resp_load && op_q == b3sic_pkg::OP_ADD && status_q == b3sic_pkg::STAT_DONE) begin
			elem_q[ELW'(depth_q)] <= x_q;
		end
		if (resp_load) begin
			rsp_status_q  <= status_q;
			rsp_depth_q   <= b3sic_pkg::DEPTH_W'(depth_n);
			rsp_largest_q <= largest_n;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.depth   = rsp_depth_q;
	assign rsp.largest = rsp_largest_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(depth_q) <= MAX_DEPTH)
		else $error("level depth beyond stack size");

	a_refused_keeps_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(resp_load && status_q != b3sic_pkg::STAT_DONE) |=> depth_q == $past(depth_q))
		else $error("refused command changed depth");

	a_write_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		(we_pair || we_trip) |-> int'(depth_q) < MAX_DEPTH)
		else $error("level write past top of stack");

endmodule
`default_nettype wire
